// ===== rtl/batched_class_request_scheduler_assert.svh =====
// assertion macros used by the scheduler engine
`ifndef BATCHED_CLASS_REQUEST_SCHEDULER_ASSERT_SVH
`define BATCHED_CLASS_REQUEST_SCHEDULER_ASSERT_SVH

// condition holds at every edge out of reset
`define BCRS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in one cycle implies consequence in the next
`define BCRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bcrs_pkg.sv =====
package bcrs_pkg;

  localparam int NUM_CTX  = 4;
  localparam int CTX_W    = 2;
  localparam int MAX_TAGS = 64;
  localparam int TAG_W    = 6;
  localparam int NCLASS   = 3;
  localparam int CLS_W    = 2;
  localparam int QIDX_W   = 4;
  localparam int NQ       = NCLASS * NUM_CTX;
  localparam int BSZ_W    = 8;

  localparam logic [CLS_W-1:0] CLS_READ  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SYNCW = 2'd1;
  localparam logic [CLS_W-1:0] CLS_OTHER = 2'd2;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [1:0] REG_READ_BATCH  = 2'd0;
  localparam logic [1:0] REG_SYNCW_BATCH = 2'd1;
  localparam logic [1:0] REG_OTHER_BATCH = 2'd2;

  localparam logic [BSZ_W-1:0] READ_BATCH_RST  = 8'd16;
  localparam logic [BSZ_W-1:0] SYNCW_BATCH_RST = 8'd8;
  localparam logic [BSZ_W-1:0] OTHER_BATCH_RST = 8'd8;

  // classified command between front and back
  typedef struct packed {
    logic             dispatch;
    logic [TAG_W-1:0] tag;
    logic [CTX_W-1:0] ctx;
    logic [CLS_W-1:0] cls;
    logic             at_head;
  } cmd_t;

  function automatic logic [CLS_W-1:0] classify(input logic [1:0] kind, input logic sync);
    logic [CLS_W-1:0] c;
    c = CLS_OTHER;
    if (kind == KIND_READ) c = CLS_READ;
    else if (kind == KIND_WRITE && sync) c = CLS_SYNCW;
    return c;
  endfunction

  function automatic logic [CLS_W-1:0] next_class(input logic [CLS_W-1:0] c);
    return (c == CLS_OTHER) ? CLS_READ : c + 2'd1;
  endfunction

endpackage

// ===== rtl/batched_class_request_scheduler.sv =====
// insert: the front queue registers the command, the sequencer takes it in ST_IDLE
// and writes the context queue in ST_INS; dispatch: ST_TRY (up to four class probes),
// ST_SPLICE (one step per context), ST_POP, and ST_LINK when the link memory is read
// for the next ready head; a new command is taken only when idle and no result waits
// reset: rst synchronous, clears queues, busy maps, class, batch count, batch sizes 16/8/8
module batched_class_request_scheduler (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       opcode,
  input  logic [5:0] request_tag,
  input  logic [1:0] ctx_index,
  input  logic [1:0] op_kind,
  input  logic       sync_flag,
  input  logic       at_head,
  output logic       empty,
  input  logic       pop,
  output logic       granted,
  output logic [5:0] granted_tag,
  output logic [1:0] granted_class,
  output logic       work_pending,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [bcrs_pkg::NCLASS-1:0][bcrs_pkg::BSZ_W-1:0] bsize;
  logic           cmd_valid;
  logic           cmd_pop;
  bcrs_pkg::cmd_t cmd;
  logic           res_valid;

  // batch size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bsize[0] <= bcrs_pkg::READ_BATCH_RST;
      bsize[1] <= bcrs_pkg::SYNCW_BATCH_RST;
      bsize[2] <= bcrs_pkg::OTHER_BATCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcrs_pkg::REG_READ_BATCH:  bsize[0] <= cfg_data;
        bcrs_pkg::REG_SYNCW_BATCH: bsize[1] <= cfg_data;
        bcrs_pkg::REG_OTHER_BATCH: bsize[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  bcrs_front u_front (
    .clk, .rst, .push, .full, .opcode, .request_tag, .ctx_index, .op_kind,
    .sync_flag, .at_head, .cmd_valid, .cmd, .cmd_pop
  );

  bcrs_engine u_engine (
    .clk, .rst, .cmd_valid, .cmd_in(cmd), .cmd_pop, .bsize,
    .res_valid, .res_pop(pop && res_valid),
    .res_granted(granted), .res_tag(granted_tag), .res_class(granted_class),
    .res_pending(work_pending)
  );

  assign empty = !res_valid;

endmodule

// ===== rtl/bcrs_front.sv =====
module bcrs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              opcode,
  input  logic [5:0]        request_tag,
  input  logic [1:0]        ctx_index,
  input  logic [1:0]        op_kind,
  input  logic              sync_flag,
  input  logic              at_head,
  output logic              cmd_valid,
  output bcrs_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  bcrs_pkg::cmd_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  bcrs_pkg::cmd_t in_cmd;

  // classify the incoming beat
  always_comb begin
    in_cmd.dispatch = (opcode == bcrs_pkg::OP_DISPATCH);
    in_cmd.tag      = request_tag;
    in_cmd.ctx      = ctx_index;
    in_cmd.cls      = bcrs_pkg::classify(op_kind, sync_flag);
    in_cmd.at_head  = at_head;
  end

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= in_cmd;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (cmd_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, cmd_pop};
    end
  end

endmodule

// ===== rtl/bcrs_engine.sv =====
`include "batched_class_request_scheduler_assert.svh"

module bcrs_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cmd_valid,
  input  bcrs_pkg::cmd_t                         cmd_in,
  output logic                                   cmd_pop,
  input  logic [bcrs_pkg::NCLASS-1:0][bcrs_pkg::BSZ_W-1:0] bsize,
  output logic                                   res_valid,
  input  logic                                   res_pop,
  output logic                                   res_granted,
  output logic [bcrs_pkg::TAG_W-1:0]             res_tag,
  output logic [bcrs_pkg::CLS_W-1:0]             res_class,
  output logic                                   res_pending
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INS    = 3'd1;
  localparam logic [2:0] ST_TRY    = 3'd2;
  localparam logic [2:0] ST_SPLICE = 3'd3;
  localparam logic [2:0] ST_POP    = 3'd4;
  localparam logic [2:0] ST_LINK   = 3'd5;

  logic [2:0]                        state;
  bcrs_pkg::cmd_t                    cmd;
  logic [bcrs_pkg::CLS_W-1:0]        cur;
  logic [bcrs_pkg::BSZ_W-1:0]        batch;
  logic [1:0]                        tries;
  logic [bcrs_pkg::CTX_W-1:0]        xidx;
  logic [bcrs_pkg::NUM_CTX-1:0]      busy [bcrs_pkg::NCLASS];
  logic [bcrs_pkg::TAG_W-1:0]        ready_head [bcrs_pkg::NCLASS];
  logic [bcrs_pkg::TAG_W-1:0]        ready_tail [bcrs_pkg::NCLASS];
  logic [bcrs_pkg::NCLASS-1:0]       nonempty;
  logic [bcrs_pkg::TAG_W-1:0]        qhead [bcrs_pkg::NQ];
  logic [bcrs_pkg::TAG_W-1:0]        qtail [bcrs_pkg::NQ];
  logic [bcrs_pkg::TAG_W-1:0]        link_mem [bcrs_pkg::MAX_TAGS];
  logic [bcrs_pkg::TAG_W-1:0]        link_rd;

  logic [bcrs_pkg::CLS_W-1:0]        qcls;
  logic [bcrs_pkg::CTX_W-1:0]        qctx;
  logic [bcrs_pkg::QIDX_W-1:0]       qidx;
  logic [bcrs_pkg::TAG_W-1:0]        qh;
  logic [bcrs_pkg::TAG_W-1:0]        qt;
  logic                              qbusy;
  logic                              link_we;
  logic [bcrs_pkg::TAG_W-1:0]        link_wa;
  logic [bcrs_pkg::TAG_W-1:0]        link_wd;

  // context queue lookup, one address a cycle
  always_comb begin
    qcls  = (state == ST_INS) ? cmd.cls : cur;
    qctx  = (state == ST_INS) ? cmd.ctx : xidx;
    qidx  = bcrs_pkg::QIDX_W'(int'(qcls) * bcrs_pkg::NUM_CTX + int'(qctx));
    qh    = qhead[qidx];
    qt    = qtail[qidx];
    qbusy = busy[qcls][qctx];
  end

  // link memory write port
  always_comb begin
    link_we = 1'b0;
    link_wa = cmd.tag;
    link_wd = qh;
    if (state == ST_INS && qbusy) begin
      link_we = 1'b1;
      if (!cmd.at_head) begin
        link_wa = qt;
        link_wd = cmd.tag;
      end
    end else if (state == ST_SPLICE && qbusy && nonempty[cur]) begin
      link_we = 1'b1;
      link_wa = ready_tail[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd <= link_mem[ready_head[cur]];
  end

  assign cmd_pop = (state == ST_IDLE) && cmd_valid && !res_valid;

  // pending work seen by the waiting result
  always_comb begin
    res_pending = |nonempty;
    for (int c = 0; c < bcrs_pkg::NCLASS; c++) res_pending = res_pending || (busy[c] != '0);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= bcrs_pkg::CLS_READ;
      batch     <= '0;
      tries     <= 2'd0;
      xidx      <= '0;
      nonempty  <= '0;
      res_valid <= 1'b0;
      for (int c = 0; c < bcrs_pkg::NCLASS; c++) busy[c] <= '0;
    end else begin
      if (res_pop) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            cmd         <= cmd_in;
            res_granted <= 1'b0;
            res_tag     <= '0;
            res_class   <= bcrs_pkg::CLS_READ;
            if (!cmd_in.dispatch) begin
              state <= ST_INS;
            end else begin
              state <= ST_TRY;
              if (batch < bsize[cur]) begin
                tries <= 2'd0;
              end else begin
                batch <= '0;
                cur   <= bcrs_pkg::next_class(cur);
                tries <= 2'd1;
              end
            end
          end
        end
        ST_INS: begin
          if (!qbusy || cmd.at_head) qhead[qidx] <= cmd.tag;
          if (!qbusy || !cmd.at_head) qtail[qidx] <= cmd.tag;
          busy[qcls][qctx] <= 1'b1;
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_TRY: begin
          if (nonempty[cur]) begin
            state <= ST_POP;
          end else if (busy[cur] != '0) begin
            xidx  <= '0;
            state <= ST_SPLICE;
          end else if (tries == 2'd3) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            batch <= '0;
            cur   <= bcrs_pkg::next_class(cur);
            tries <= tries + 2'd1;
          end
        end
        ST_SPLICE: begin
          if (qbusy) begin
            if (!nonempty[cur]) ready_head[cur] <= qh;
            ready_tail[cur]  <= qt;
            nonempty[cur]    <= 1'b1;
            busy[cur][xidx]  <= 1'b0;
          end
          xidx <= xidx + 1'b1;
          if (int'(xidx) == bcrs_pkg::NUM_CTX - 1) state <= ST_POP;
        end
        ST_POP: begin
          res_granted <= 1'b1;
          res_tag     <= ready_head[cur];
          res_class   <= cur;
          batch       <= batch + 1'b1;
          if (ready_head[cur] == ready_tail[cur]) begin
            nonempty[cur] <= 1'b0;
            res_valid     <= 1'b1;
            state         <= ST_IDLE;
          end else begin
            state <= ST_LINK;
          end
        end
        ST_LINK: begin
          ready_head[cur] <= link_rd;
          res_valid       <= 1'b1;
          state           <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BCRS_ASSERT_ALWAYS(a_busy_no_result, (state == ST_IDLE) || !res_valid, "result while busy")
  `BCRS_ASSERT_ALWAYS(a_idle_tag_zero, !res_valid || res_granted || (res_tag == '0), "ungranted tag")
  `BCRS_ASSERT_NEXT(a_held_result, res_valid && !res_pop, res_valid && $stable(res_tag), "result lost")
  `BCRS_ASSERT_ALWAYS(a_class_range, cur != 2'd3, "class out of range")

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_PER_PHASE = 113;
  localparam int CYCLE_LIMIT    = 400000;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;
  localparam logic [1:0] REG_NONE   = 2'd3;

  typedef struct {
    logic                       g;
    logic [bcrs_pkg::TAG_W-1:0] t;
    logic [bcrs_pkg::CLS_W-1:0] c;
    logic                       p;
  } grant_beat_t;

  typedef struct {
    logic                       op;
    logic [bcrs_pkg::TAG_W-1:0] tag;
    logic [bcrs_pkg::CTX_W-1:0] ctx;
    logic [1:0]                 kind;
    logic                       sync;
    logic                       head;
    bit                         typed;
    grant_beat_t                want;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic opcode = 0;
  logic [5:0] request_tag = 0;
  logic [1:0] ctx_index = 0;
  logic [1:0] op_kind = 0;
  logic sync_flag = 0;
  logic at_head = 0;
  logic pop = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [7:0] cfg_data = 0;
  logic full, empty, granted, work_pending;
  logic [5:0] granted_tag;
  logic [1:0] granted_class;

  batched_class_request_scheduler DUT (.*);

  // clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // scheduler state as predicted
  logic [bcrs_pkg::TAG_W-1:0] link_mem [bcrs_pkg::MAX_TAGS];
  logic [bcrs_pkg::TAG_W-1:0] cq_head [bcrs_pkg::NQ];
  logic [bcrs_pkg::TAG_W-1:0] cq_tail [bcrs_pkg::NQ];
  logic [bcrs_pkg::NUM_CTX-1:0] busy_map [bcrs_pkg::NCLASS];
  logic [bcrs_pkg::TAG_W-1:0] rdy_head [bcrs_pkg::NCLASS];
  logic [bcrs_pkg::TAG_W-1:0] rdy_tail [bcrs_pkg::NCLASS];
  bit rdy_valid [bcrs_pkg::NCLASS];
  logic [bcrs_pkg::CLS_W-1:0] cur_cls = bcrs_pkg::CLS_READ;
  logic [7:0] batch_cnt = 0;
  logic [7:0] batch_lim [bcrs_pkg::NCLASS] = '{bcrs_pkg::READ_BATCH_RST,
                                               bcrs_pkg::SYNCW_BATCH_RST,
                                               bcrs_pkg::OTHER_BATCH_RST};
  bit tag_queued [bcrs_pkg::MAX_TAGS];
  int n_queued = 0;

  grant_beat_t pending_grants [$];
  int hold_cycles = 0;
  int errors = 0;
  int n_items = 0;
  int n_grants [bcrs_pkg::NCLASS] = '{0, 0, 0};
  int n_idle_dispatch = 0;

  // move busy context queues onto the ready list
  function automatic void splice_class(input logic [bcrs_pkg::CLS_W-1:0] c);
    int q;
    for (int x = 0; x < bcrs_pkg::NUM_CTX; x++) begin
      q = c * bcrs_pkg::NUM_CTX + x;
      if (busy_map[c][x]) begin
        if (rdy_valid[c]) link_mem[rdy_tail[c]] = cq_head[q];
        else rdy_head[c] = cq_head[q];
        rdy_tail[c] = cq_tail[q];
        rdy_valid[c] = 1;
        busy_map[c][x] = 0;
      end
    end
  endfunction

  function automatic bit take_from(input logic [bcrs_pkg::CLS_W-1:0] c,
                                   output logic [bcrs_pkg::TAG_W-1:0] t);
    if (!rdy_valid[c]) begin
      if (busy_map[c] == 0) return 0;
      splice_class(c);
    end
    t = rdy_head[c];
    if (rdy_head[c] == rdy_tail[c]) rdy_valid[c] = 0;
    else rdy_head[c] = link_mem[rdy_head[c]];
    batch_cnt = batch_cnt + 8'd1;
    return 1;
  endfunction

  function automatic grant_beat_t next_grant(input stim_row_t r);
    grant_beat_t b;
    logic [bcrs_pkg::CLS_W-1:0] c;
    logic [bcrs_pkg::TAG_W-1:0] t;
    int q;
    bit ok;
    b = '{1'b0, '0, bcrs_pkg::CLS_READ, 1'b0};
    t = '0;
    if (r.op == bcrs_pkg::OP_INSERT) begin
      if (r.kind == bcrs_pkg::KIND_READ) c = bcrs_pkg::CLS_READ;
      else if (r.kind == bcrs_pkg::KIND_WRITE && r.sync) c = bcrs_pkg::CLS_SYNCW;
      else c = bcrs_pkg::CLS_OTHER;
      q = c * bcrs_pkg::NUM_CTX + r.ctx;
      if (!busy_map[c][r.ctx]) begin
        cq_head[q] = r.tag;
        cq_tail[q] = r.tag;
      end else if (r.head) begin
        link_mem[r.tag] = cq_head[q];
        cq_head[q] = r.tag;
      end else begin
        link_mem[cq_tail[q]] = r.tag;
        cq_tail[q] = r.tag;
      end
      busy_map[c][r.ctx] = 1;
      tag_queued[r.tag] = 1;
      n_queued++;
    end else begin
      ok = 0;
      if (batch_cnt < batch_lim[cur_cls]) ok = take_from(cur_cls, t);
      if (!ok) begin
        batch_cnt = 0;
        for (int i = 0; i < bcrs_pkg::NCLASS && !ok; i++) begin
          cur_cls = (cur_cls == bcrs_pkg::CLS_OTHER) ? bcrs_pkg::CLS_READ : cur_cls + 2'd1;
          ok = take_from(cur_cls, t);
        end
      end
      if (ok) begin
        b.g = 1;
        b.t = t;
        b.c = cur_cls;
        tag_queued[t] = 0;
        n_queued--;
      end
    end
    for (int k = 0; k < bcrs_pkg::NCLASS; k++)
      if (rdy_valid[k] || busy_map[k] != 0) b.p = 1;
    return b;
  endfunction

  // drive one beat and wait for it to be taken
  task automatic offer(input stim_row_t r, input int gap);
    grant_beat_t b;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    opcode <= r.op;
    request_tag <= r.tag;
    ctx_index <= r.ctx;
    op_kind <= r.kind;
    sync_flag <= r.sync;
    at_head <= r.head;
    do @(posedge clk); while (full);
    b = next_grant(r);
    pending_grants.push_back(r.typed ? r.want : b);
    n_items++;
  endtask

  function automatic stim_row_t random_row();
    stim_row_t r;
    r = '{bcrs_pkg::OP_DISPATCH, 6'($urandom), 2'($urandom), 2'($urandom),
          1'($urandom), 1'($urandom), 0, '{0, 0, 0, 0}};
    if (n_queued < bcrs_pkg::MAX_TAGS && ($urandom_range(99) < 55 || n_queued == 0)) begin
      r.op = bcrs_pkg::OP_INSERT;
      do r.tag = 6'($urandom_range(bcrs_pkg::MAX_TAGS - 1)); while (tag_queued[r.tag]);
    end
    return r;
  endfunction

  // block idle: write batch sizes and the unused index
  task automatic set_batches(input logic [7:0] rd, input logic [7:0] sw, input logic [7:0] ot);
    push <= 0;
    wait (pending_grants.size() == 0);
    repeat (30) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= bcrs_pkg::REG_READ_BATCH;  cfg_data <= rd; @(posedge clk);
    cfg_index <= bcrs_pkg::REG_SYNCW_BATCH; cfg_data <= sw; @(posedge clk);
    cfg_index <= bcrs_pkg::REG_OTHER_BATCH; cfg_data <= ot; @(posedge clk);
    cfg_index <= REG_NONE;                  cfg_data <= 8'($urandom); @(posedge clk);
    cfg_we <= 0;
    batch_lim = '{rd, sw, ot};
  endtask

  // result side: random pop gaps, one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: tag %0d", granted_tag);
      end else begin
        grant_beat_t w;
        w = pending_grants.pop_front();
        if (granted !== w.g || granted_tag !== w.t || granted_class !== w.c ||
            work_pending !== w.p) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp g%0d t%0d c%0d p%0d got g%0d t%0d c%0d p%0d",
                     w.g, w.t, w.c, w.p, granted, granted_tag, granted_class,
                     work_pending);
        end else if (w.g) n_grants[w.c]++;
        else if (w.p === 1'b0 && granted === 1'b0) n_idle_dispatch++;
      end
    end
  end

  // cycle limit
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cyc);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t dir [$];
    int bursty;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed beats: empty dispatch, every class and kind, head and tail inserts
    dir.push_back('{bcrs_pkg::OP_DISPATCH, 0, 0, bcrs_pkg::KIND_READ, 0, 0, 1,
                    '{0, 0, bcrs_pkg::CLS_READ, 0}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 63, 3, bcrs_pkg::KIND_READ, 0, 0, 1,
                    '{0, 0, bcrs_pkg::CLS_READ, 1}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 0, 0, bcrs_pkg::KIND_WRITE, 1, 1, 1,
                    '{0, 0, bcrs_pkg::CLS_READ, 1}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 1, 0, bcrs_pkg::KIND_WRITE, 0, 0, 0, '{0, 0, 0, 0}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 2, 1, KIND_BAD, 1, 0, 0, '{0, 0, 0, 0}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 3, 1, KIND_OTHER, 0, 1, 0, '{0, 0, 0, 0}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 4, 1, KIND_OTHER, 1, 1, 0, '{0, 0, 0, 0}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 5, 1, KIND_OTHER, 0, 0, 0, '{0, 0, 0, 0}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 6, 0, bcrs_pkg::KIND_READ, 1, 1, 0, '{0, 0, 0, 0}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 7, 3, bcrs_pkg::KIND_READ, 0, 0, 0, '{0, 0, 0, 0}});
    dir.push_back('{bcrs_pkg::OP_INSERT, 42, 2, bcrs_pkg::KIND_WRITE, 1, 0, 0, '{0, 0, 0, 0}});
    for (int i = 0; i < 11; i++)
      dir.push_back('{bcrs_pkg::OP_DISPATCH, 0, 0, bcrs_pkg::KIND_READ, 0, 0, 0,
                      '{0, 0, 0, 0}});
    dir.push_back('{bcrs_pkg::OP_DISPATCH, 63, 3, KIND_BAD, 1, 1, 1,
                    '{0, 0, bcrs_pkg::CLS_READ, 0}});
    @(posedge clk);
    foreach (dir[i]) offer(dir[i], $urandom_range(16));

    // random phases over the reset and several other batch settings, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_batches(8'd0, 8'd0, 8'd0);
        2: set_batches(8'd255, 8'd255, 8'd255);
        3: set_batches(8'd1, 8'd2, 8'd3);
        4: set_batches(8'($urandom_range(1, 6)), 8'($urandom_range(6)),
                       8'($urandom_range(1, 6)));
        5: set_batches(8'd3, 8'd255, 8'd0);
        default: ;
      endcase
      if (ph == 2) hold_cycles = 600;
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        bursty = (i % 40) < 12;
        offer(random_row(), bursty ? 0 : $urandom_range(16));
      end
    end
    push <= 0;

    wait (pending_grants.size() == 0);
    repeat (40) @(posedge clk);
    $display("%0d beats sent; grants read/sync-write/other %0d/%0d/%0d, %0d idle dispatches",
             n_items, n_grants[0], n_grants[1], n_grants[2], n_idle_dispatch);
    $display("batch sizes zero, one, mixed and 255 covered, with a long result stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
